@@ src/sexp_pkg.sv @@
// ----------------------------------------------------------------------------
// sexp_pkg
// Shared types, codes and character classes for the s-expression tokenizer.
// ----------------------------------------------------------------------------
package sexp_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_NUMBER,
		MODE_NUMDOT,
		MODE_FRAC,
		MODE_IDENT,
		MODE_STRING
	} mode_t;

	typedef enum logic [3:0] {
		KIND_LBR   = 4'd0,
		KIND_RBR   = 4'd1,
		KIND_STR   = 4'd2,
		KIND_NUM   = 4'd3,
		KIND_ID    = 4'd4,
		KIND_BOOL  = 4'd5,
		KIND_NIL   = 4'd6,
		KIND_ERR   = 4'd7,
		KIND_EOF   = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_UNEXPECTED = 2'd1,
		ERR_UNTERM_STR = 2'd2
	} err_t;

	typedef struct packed {
		logic [15:0] line;
		logic [15:0] length;
		logic [15:0] start;
		err_t        err;
		kind_t       kind;
	} token_t;

	typedef struct packed {
		token_t [2:0] tok;
		logic   [1:0] cnt;
	} tok_batch_t;

	localparam logic [7:0]  CH_LBR    = 8'h5B;
	localparam logic [7:0]  CH_RBR    = 8'h5D;
	localparam logic [7:0]  CH_SEMI   = 8'h3B;
	localparam logic [7:0]  CH_QUOTE  = 8'h22;
	localparam logic [7:0]  CH_DOT    = 8'h2E;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_NUL    = 8'h00;
	localparam logic [31:0] KW_TRUE   = 32'h74727565;
	localparam logic [39:0] KW_FALSE  = 40'h66616C7365;
	localparam logic [23:0] KW_NIL    = 24'h6E696C;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0D};
	endfunction

	function automatic logic is_sym(input logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F, 8'h2D, 8'h2B, 8'h2A,
			8'h2F, 8'h3D, 8'h3E, 8'h3C, 8'h21, 8'h3F, 8'h26, 8'h7C, 8'h25,
			8'h5E, 8'h7E};
	endfunction

endpackage

@@ src/sexp_scan.sv @@
// ----------------------------------------------------------------------------
// sexp_scan
// Scanner state and next-state logic: classifies one byte and builds the
// batch of up to three tokens that the byte completes.
// ----------------------------------------------------------------------------
module sexp_scan #(
	parameter int OFFSET_BITS = 16,
	parameter int LINE_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           src_byte,
	input  logic                 end_of_source,
	output sexp_pkg::tok_batch_t batch
);

	sexp_pkg::mode_t        mode_q, mode_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [OFFSET_BITS-1:0] tb_q, tb_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [39:0]            win_q, win_n;

	logic [OFFSET_BITS:0]   span, off_w, tb_w, dot_w;
	logic [15:0]            line16;
	sexp_pkg::kind_t        id_kind;
	sexp_pkg::token_t       tok_a, tok_b, tok_c;
	logic                   a_v, b_v, c_v;
	logic                   run_idle, line_inc;

	function automatic logic [15:0] sat_off(input logic [OFFSET_BITS:0] v);
		logic [OFFSET_BITS+16:0] ext;
		ext = (OFFSET_BITS+17)'(v);
		return (ext > (OFFSET_BITS+17)'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
	endfunction

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [LINE_BITS+16:0] ext;
		ext = (LINE_BITS+17)'(v);
		return (ext > (LINE_BITS+17)'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
	endfunction

	function automatic sexp_pkg::token_t mk(input sexp_pkg::kind_t k, input sexp_pkg::err_t e,
		input logic [OFFSET_BITS:0] st, input logic [OFFSET_BITS:0] ln,
		input logic [15:0] li);
		sexp_pkg::token_t t;
		t.kind   = k;
		t.err    = e;
		t.start  = sat_off(st);
		t.length = sat_off(ln);
		t.line   = li;
		return t;
	endfunction

	always_comb begin
		off_w  = {1'b0, off_q};
		tb_w   = {1'b0, tb_q};
		span   = (off_q >= tb_q) ? (off_w - tb_w) : '0;
		dot_w  = (off_q != '0) ? (off_w - (OFFSET_BITS+1)'(1)) : '0;
		line16 = sat_line(line_q);
		if (span == (OFFSET_BITS+1)'(4) && win_q[31:0] == sexp_pkg::KW_TRUE) begin
			id_kind = sexp_pkg::KIND_BOOL;
		end else if (span == (OFFSET_BITS+1)'(5) && win_q == sexp_pkg::KW_FALSE) begin
			id_kind = sexp_pkg::KIND_BOOL;
		end else if (span == (OFFSET_BITS+1)'(3) && win_q[23:0] == sexp_pkg::KW_NIL) begin
			id_kind = sexp_pkg::KIND_NIL;
		end else begin
			id_kind = sexp_pkg::KIND_ID;
		end
	end

	always_comb begin
		mode_n   = mode_q;
		off_n    = off_q;
		tb_n     = tb_q;
		line_n   = line_q;
		win_n    = win_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		c_v      = 1'b0;
		run_idle = 1'b0;
		line_inc = 1'b0;
		tok_a    = mk(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, tb_w, span, line16);
		tok_b    = mk(sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNEXPECTED, dot_w,
			(OFFSET_BITS+1)'(1), line16);
		tok_c    = mk(sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNEXPECTED, off_w,
			(OFFSET_BITS+1)'(1), line16);
		if (end_of_source || src_byte == sexp_pkg::CH_NUL) begin
			case (mode_q)
				sexp_pkg::MODE_NUMBER, sexp_pkg::MODE_FRAC: begin
					a_v = 1'b1;
				end
				sexp_pkg::MODE_NUMDOT: begin
					a_v   = 1'b1;
					b_v   = 1'b1;
					tok_a = mk(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, tb_w,
						(span != '0) ? span - (OFFSET_BITS+1)'(1) : '0, line16);
				end
				sexp_pkg::MODE_IDENT: begin
					a_v   = 1'b1;
					tok_a = mk(id_kind, sexp_pkg::ERR_NONE, tb_w, span, line16);
				end
				sexp_pkg::MODE_STRING: begin
					a_v   = 1'b1;
					tok_a = mk(sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNTERM_STR, tb_w, span, line16);
				end
				default: begin
				end
			endcase
			c_v    = 1'b1;
			tok_c  = mk(sexp_pkg::KIND_EOF, sexp_pkg::ERR_NONE, off_w, '0, line16);
			mode_n = sexp_pkg::MODE_IDLE;
			off_n  = '0;
			tb_n   = '0;
			line_n = LINE_BITS'(1);
			win_n  = '0;
		end else begin
			case (mode_q)
				sexp_pkg::MODE_COMMENT: begin
					if (src_byte == sexp_pkg::CH_LF) begin
						line_inc = 1'b1;
						mode_n   = sexp_pkg::MODE_IDLE;
					end
				end
				sexp_pkg::MODE_NUMBER: begin
					if (src_byte == sexp_pkg::CH_DOT) begin
						mode_n = sexp_pkg::MODE_NUMDOT;
					end else if (!sexp_pkg::is_digit(src_byte)) begin
						a_v      = 1'b1;
						run_idle = 1'b1;
					end
				end
				sexp_pkg::MODE_NUMDOT: begin
					if (sexp_pkg::is_digit(src_byte)) begin
						mode_n = sexp_pkg::MODE_FRAC;
					end else begin
						a_v      = 1'b1;
						b_v      = 1'b1;
						run_idle = 1'b1;
						tok_a    = mk(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, tb_w,
							(span != '0) ? span - (OFFSET_BITS+1)'(1) : '0, line16);
					end
				end
				sexp_pkg::MODE_FRAC: begin
					if (!sexp_pkg::is_digit(src_byte)) begin
						a_v      = 1'b1;
						run_idle = 1'b1;
					end
				end
				sexp_pkg::MODE_IDENT: begin
					if (sexp_pkg::is_sym(src_byte) || sexp_pkg::is_digit(src_byte)) begin
						win_n = {win_q[31:0], src_byte};
					end else begin
						a_v      = 1'b1;
						run_idle = 1'b1;
						tok_a    = mk(id_kind, sexp_pkg::ERR_NONE, tb_w, span, line16);
					end
				end
				sexp_pkg::MODE_STRING: begin
					if (src_byte == sexp_pkg::CH_QUOTE) begin
						a_v    = 1'b1;
						mode_n = sexp_pkg::MODE_IDLE;
						tok_a  = mk(sexp_pkg::KIND_STR, sexp_pkg::ERR_NONE, tb_w,
							span + (OFFSET_BITS+1)'(1), line16);
					end else if (src_byte == sexp_pkg::CH_LF) begin
						line_inc = 1'b1;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase
			if (run_idle) begin
				mode_n = sexp_pkg::MODE_IDLE;
				if (sexp_pkg::is_space(src_byte)) begin
					mode_n = sexp_pkg::MODE_IDLE;
				end else if (src_byte == sexp_pkg::CH_LF) begin
					line_inc = 1'b1;
				end else if (src_byte == sexp_pkg::CH_SEMI) begin
					mode_n = sexp_pkg::MODE_COMMENT;
				end else if (sexp_pkg::is_digit(src_byte)) begin
					tb_n   = off_q;
					mode_n = sexp_pkg::MODE_NUMBER;
				end else if (sexp_pkg::is_sym(src_byte)) begin
					tb_n   = off_q;
					win_n  = {32'h0, src_byte};
					mode_n = sexp_pkg::MODE_IDENT;
				end else if (src_byte == sexp_pkg::CH_LBR) begin
					c_v   = 1'b1;
					tok_c = mk(sexp_pkg::KIND_LBR, sexp_pkg::ERR_NONE, off_w,
						(OFFSET_BITS+1)'(1), line16);
				end else if (src_byte == sexp_pkg::CH_RBR) begin
					c_v   = 1'b1;
					tok_c = mk(sexp_pkg::KIND_RBR, sexp_pkg::ERR_NONE, off_w,
						(OFFSET_BITS+1)'(1), line16);
				end else if (src_byte == sexp_pkg::CH_QUOTE) begin
					tb_n   = off_q;
					mode_n = sexp_pkg::MODE_STRING;
				end else begin
					c_v = 1'b1;
				end
			end
			if (line_inc && line_q != '1) begin
				line_n = line_q + LINE_BITS'(1);
			end
			if (off_q != '1) begin
				off_n = off_q + OFFSET_BITS'(1);
			end
		end
	end

	// pack: the dot error only ever follows the number token
	always_comb begin
		batch.tok[0] = a_v ? tok_a : tok_c;
		batch.tok[1] = b_v ? tok_b : tok_c;
		batch.tok[2] = tok_c;
		batch.cnt    = 2'(a_v) + 2'(b_v) + 2'(c_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sexp_pkg::MODE_IDLE;
			off_q  <= '0;
			tb_q   <= '0;
			line_q <= LINE_BITS'(1);
			win_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_n;
			off_q  <= off_n;
			tb_q   <= tb_n;
			line_q <= line_n;
			win_q  <= win_n;
		end
	end

endmodule

@@ src/sexp_outq.sv @@
// ----------------------------------------------------------------------------
// sexp_outq
// Result register: holds the token batch of one byte and sends it one
// beat at a time, tlast on the final token of the batch.
// ----------------------------------------------------------------------------
module sexp_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sexp_pkg::tok_batch_t batch,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output sexp_pkg::token_t     m_tok,
	output logic                 m_tlast
);

	sexp_pkg::token_t ent_q [3];
	logic [1:0]       cnt_q;
	logic [1:0]       rd_q;

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tok    = ent_q[rd_q];
	assign m_tlast  = (cnt_q == 2'd1);
	assign free     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.cnt;
			rd_q  <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q[0] <= batch.tok[0];
			ent_q[1] <= batch.tok[1];
			ent_q[2] <= batch.tok[2];
		end
	end

endmodule

@@ src/s_expression_tokenizer.sv @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer
// Streaming lexer for bracketed s-expressions: one source byte per beat in,
// tokens with kind, error code, start, length and line out.
// ----------------------------------------------------------------------------
// Pipeline: each input beat is registered in the input stage, and the token
//   batch of that byte is registered in the result register, which sends it.
// Throughput: one byte per cycle while m_tready is high; a byte that yields
//   two or three tokens holds the input while the result register drains
//   one token per cycle while m_tready is high.
// Reset: asynchronous, active low; line 1, offset 0, no pending token.
module s_expression_tokenizer #(
	parameter int OFFSET_BITS = 16,
	parameter int LINE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] src_byte
	input  logic [0:0]  s_tuser,   // [0] end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] tok_start, [31:16] tok_length, [47:32] tok_line
	output logic [5:0]  m_tuser,   // [3:0] tok_kind, [5:4] err_code
	output logic        m_tlast    // run_last
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eos_s1;
	logic                 free;
	logic                 fire;
	sexp_pkg::tok_batch_t batch;
	sexp_pkg::token_t     m_tok;

	assign fire     = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tuser[0];
		end
	end

	sexp_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.src_byte     (byte_s1),
		.end_of_source(eos_s1),
		.batch        (batch)
	);

	sexp_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.batch   (batch),
		.free    (free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tok   (m_tok),
		.m_tlast (m_tlast)
	);

	assign m_tdata = {m_tok.line, m_tok.length, m_tok.start};
	assign m_tuser = {m_tok.err, m_tok.kind};

endmodule

@@ tb/sv/s_expression_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_expression_tokenizer_tb
// Self-checking bench for the s-expression tokenizer. Source bytes go in
// on the slave stream and tokens come back on the master stream. Each token
// is compared field by field with a cycle-free lexer model kept in the bench
// or with a typed row of the directed table, which runs first. Random, mostly
// well-formed source text follows. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_tb;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 4;
	localparam int RANDOM_BYTES   = 260;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int COUNT_MAX      = 65535;
	localparam int MAX_PRINTED    = 40;
	localparam int MAX_PER_BYTE   = 3;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef struct {
		logic [7:0]      ch;
		logic            eos;
		bit              typed;
		sexp_pkg::kind_t kind;
		sexp_pkg::err_t  err;
		int              start;
		int              len;
		int              line;
	} src_row_t;

	typedef struct {
		sexp_pkg::kind_t kind;
		sexp_pkg::err_t  err;
		logic [15:0]     start;
		logic [15:0]     length;
		logic [15:0]     line;
		logic            last;
	} token_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] src_byte
	logic [0:0]  s_tuser = 1'b0;    // [0] end_of_source
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // [15:0] tok_start, [31:16] tok_length, [47:32] tok_line
	logic [5:0]  m_tuser;           // [3:0] tok_kind, [5:4] err_code
	logic        m_tlast;

	token_rec_t pending_tokens[$];
	src_row_t   sent_rows[$];
	src_row_t   rand_q[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         sink_wait = 0;
	bit         src_calm = 1'b0;
	bit         sink_calm = 1'b0;

	sexp_pkg::mode_t lex_mode = sexp_pkg::MODE_IDLE;
	int              lex_pos = 0;
	int              lex_begin = 0;
	int              lex_line = 1;
	logic [39:0]     kw_win = '0;
	int              step_tokens = 0;

	string word_pool [10] = '{"true", "false", "nil", "tru", "falsey", "xfalse", "nil0",
		"ni", "True", "atrue"};
	string lead_chars = "abefilnrstuxzAZ";
	string sym_chars  = "abefilnrstuxzAZ_-+*/=><!?&|%^~09";
	string after_dot  = " []a.;";

	s_expression_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic bit digit_ch(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit ident_ch(input logic [7:0] c);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return 1'b1;
		case (c)
			"_", "-", "+", "*", "/", "=", ">", "<", "!", "?", "&", "|", "%", "^", "~":
				return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void push_token(input sexp_pkg::kind_t k, input sexp_pkg::err_t e,
		input int st, input int ln);
		token_rec_t t;
		if (step_tokens >= MAX_PER_BYTE) return;
		t.kind   = k;
		t.err    = e;
		t.start  = st > COUNT_MAX ? 16'hFFFF : 16'(st);
		t.length = ln > COUNT_MAX ? 16'hFFFF : 16'(ln);
		t.line   = lex_line > COUNT_MAX ? 16'hFFFF : 16'(lex_line);
		t.last   = 1'b0;
		pending_tokens.push_back(t);
		step_tokens++;
	endfunction

	function automatic int lex_span();
		return lex_pos >= lex_begin ? lex_pos - lex_begin : 0;
	endfunction

	function automatic void bump_line();
		if (lex_line < COUNT_MAX) lex_line++;
	endfunction

	function automatic void emit_ident();
		int n;
		sexp_pkg::kind_t k;
		n = lex_span();
		k = sexp_pkg::KIND_ID;
		if (n == 4 && kw_win[31:0] == "true") k = sexp_pkg::KIND_BOOL;
		else if (n == 5 && kw_win == "false") k = sexp_pkg::KIND_BOOL;
		else if (n == 3 && kw_win[23:0] == "nil") k = sexp_pkg::KIND_NIL;
		push_token(k, sexp_pkg::ERR_NONE, lex_begin, n);
	endfunction

	// number is cut before the held dot, the dot itself is an error
	function automatic void flush_dot();
		int n;
		n = lex_span();
		push_token(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, lex_begin, n > 0 ? n - 1 : 0);
		push_token(sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNEXPECTED,
			lex_pos > 0 ? lex_pos - 1 : 0, 1);
	endfunction

	function automatic void scan_idle(input logic [7:0] c);
		lex_mode = sexp_pkg::MODE_IDLE;
		if (c == CH_SP || c == CH_TAB || c == CH_CR) return;
		if (c == sexp_pkg::CH_LF) begin
			bump_line();
			return;
		end
		if (c == sexp_pkg::CH_SEMI) begin
			lex_mode = sexp_pkg::MODE_COMMENT;
			return;
		end
		if (digit_ch(c)) begin
			lex_begin = lex_pos;
			lex_mode = sexp_pkg::MODE_NUMBER;
			return;
		end
		if (ident_ch(c)) begin
			lex_begin = lex_pos;
			kw_win = {32'h0, c};
			lex_mode = sexp_pkg::MODE_IDENT;
			return;
		end
		if (c == sexp_pkg::CH_LBR)
			push_token(sexp_pkg::KIND_LBR, sexp_pkg::ERR_NONE, lex_pos, 1);
		else if (c == sexp_pkg::CH_RBR)
			push_token(sexp_pkg::KIND_RBR, sexp_pkg::ERR_NONE, lex_pos, 1);
		else if (c == sexp_pkg::CH_QUOTE) begin
			lex_begin = lex_pos;
			lex_mode = sexp_pkg::MODE_STRING;
		end else push_token(sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNEXPECTED, lex_pos, 1);
	endfunction

	function automatic void scan_byte(input logic [7:0] c);
		case (lex_mode)
			sexp_pkg::MODE_COMMENT: begin
				if (c == sexp_pkg::CH_LF) begin
					bump_line();
					lex_mode = sexp_pkg::MODE_IDLE;
				end
			end
			sexp_pkg::MODE_NUMBER: begin
				if (c == sexp_pkg::CH_DOT) lex_mode = sexp_pkg::MODE_NUMDOT;
				else if (!digit_ch(c)) begin
					push_token(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, lex_begin, lex_span());
					scan_idle(c);
				end
			end
			sexp_pkg::MODE_NUMDOT: begin
				if (digit_ch(c)) lex_mode = sexp_pkg::MODE_FRAC;
				else begin
					flush_dot();
					scan_idle(c);
				end
			end
			sexp_pkg::MODE_FRAC: begin
				if (!digit_ch(c)) begin
					push_token(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, lex_begin, lex_span());
					scan_idle(c);
				end
			end
			sexp_pkg::MODE_IDENT: begin
				if (ident_ch(c) || digit_ch(c)) kw_win = {kw_win[31:0], c};
				else begin
					emit_ident();
					scan_idle(c);
				end
			end
			sexp_pkg::MODE_STRING: begin
				if (c == sexp_pkg::CH_QUOTE) begin
					push_token(sexp_pkg::KIND_STR, sexp_pkg::ERR_NONE, lex_begin,
						lex_span() + 1);
					lex_mode = sexp_pkg::MODE_IDLE;
				end else if (c == sexp_pkg::CH_LF) bump_line();
			end
			default: scan_idle(c);
		endcase
		if (lex_pos < COUNT_MAX) lex_pos++;
	endfunction

	function automatic void finish_source();
		case (lex_mode)
			sexp_pkg::MODE_NUMBER, sexp_pkg::MODE_FRAC:
				push_token(sexp_pkg::KIND_NUM, sexp_pkg::ERR_NONE, lex_begin, lex_span());
			sexp_pkg::MODE_NUMDOT: flush_dot();
			sexp_pkg::MODE_IDENT: emit_ident();
			sexp_pkg::MODE_STRING:
				push_token(sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNTERM_STR, lex_begin,
					lex_span());
			default: ;
		endcase
		push_token(sexp_pkg::KIND_EOF, sexp_pkg::ERR_NONE, lex_pos, 0);
		lex_mode = sexp_pkg::MODE_IDLE;
		lex_pos = 0;
		lex_begin = 0;
		lex_line = 1;
		kw_win = '0;
	endfunction

	function automatic void lex_byte(input logic [7:0] c, input logic eos);
		int n0;
		token_rec_t t;
		step_tokens = 0;
		n0 = pending_tokens.size();
		if (eos || c == sexp_pkg::CH_NUL) finish_source();
		else scan_byte(c);
		if (pending_tokens.size() > n0) begin
			t = pending_tokens.pop_back();
			t.last = 1'b1;
			pending_tokens.push_back(t);
		end
	endfunction

	function automatic src_row_t plain_row(input logic [7:0] c, input logic eos);
		src_row_t r;
		r = '{c, eos, 1'b0, sexp_pkg::KIND_LBR, sexp_pkg::ERR_NONE, 0, 0, 0};
		return r;
	endfunction

	function automatic void add_ch(input logic [7:0] c);
		rand_q.push_back(plain_row(c, 1'b0));
	endfunction

	function automatic void add_end();
		if ($urandom_range(0, 1) == 0) rand_q.push_back(plain_row(8'($urandom_range(0, 255)), 1'b1));
		else add_ch(sexp_pkg::CH_NUL);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
	endtask

	// hold valid across back-to-back beats, drop it only before a gap
	task automatic send_row(input src_row_t r);
		int gap;
		gap = src_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sent_rows.push_back(r);
		s_tvalid <= 1'b1;
		s_tdata  <= r.ch;
		s_tuser  <= r.eos;
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			m_tready <= 1'b0;
			sink_wait--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
			if (!sink_calm) sink_wait = pick_gap();
		end
	end

	always @(posedge clk) begin : monitor
		src_row_t row;
		token_rec_t want;
		int n_prior;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				row = sent_rows.pop_front();
				n_prior = pending_tokens.size();
				lex_byte(s_tdata, s_tuser[0]);
				if (row.typed) begin
					while (pending_tokens.size() > n_prior) void'(pending_tokens.pop_back());
					pending_tokens.push_back('{row.kind, row.err, 16'(row.start),
						16'(row.len), 16'(row.line), 1'b1});
				end
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (pending_tokens.size() == 0) begin
					report_mismatch($sformatf("token kind %0d start %0d with none pending",
						m_tuser[3:0], m_tdata[15:0]));
				end else begin
					want = pending_tokens.pop_front();
					if (m_tuser[3:0] !== want.kind)
						report_mismatch($sformatf("kind got %0d want %0d", m_tuser[3:0], want.kind));
					if (m_tuser[5:4] !== want.err)
						report_mismatch($sformatf("err got %0d want %0d", m_tuser[5:4], want.err));
					if (m_tdata[15:0] !== want.start)
						report_mismatch($sformatf("start got %0d want %0d", m_tdata[15:0],
							want.start));
					if (m_tdata[31:16] !== want.length)
						report_mismatch($sformatf("length got %0d want %0d", m_tdata[31:16],
							want.length));
					if (m_tdata[47:32] !== want.line)
						report_mismatch($sformatf("line got %0d want %0d", m_tdata[47:32],
							want.line));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("tlast got %0b want %0b", m_tlast, want.last));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		src_row_t dir_tab [29];
		int pick;
		int n;
		int k;
		string word;
		logic [7:0] ch;
		dir_tab = '{
			'{sexp_pkg::CH_LBR, 1'b0, 1'b1, sexp_pkg::KIND_LBR, sexp_pkg::ERR_NONE, 0, 1, 1},
			'{sexp_pkg::CH_RBR, 1'b0, 1'b1, sexp_pkg::KIND_RBR, sexp_pkg::ERR_NONE, 1, 1, 1},
			'{8'hFF, 1'b0, 1'b1, sexp_pkg::KIND_ERR, sexp_pkg::ERR_UNEXPECTED, 2, 1, 1},
			plain_row(sexp_pkg::CH_LF, 1'b0),
			plain_row("n", 1'b0), plain_row("i", 1'b0), plain_row("l", 1'b0),
			plain_row(sexp_pkg::CH_RBR, 1'b0),
			plain_row("1", 1'b0), plain_row(sexp_pkg::CH_DOT, 1'b0),
			plain_row(sexp_pkg::CH_LBR, 1'b0),
			plain_row("0", 1'b0), plain_row(sexp_pkg::CH_DOT, 1'b0), plain_row("9", 1'b0),
			plain_row(sexp_pkg::CH_SEMI, 1'b0), plain_row(sexp_pkg::CH_LF, 1'b0),
			plain_row(sexp_pkg::CH_QUOTE, 1'b0), plain_row(sexp_pkg::CH_LF, 1'b0),
			plain_row(sexp_pkg::CH_QUOTE, 1'b0),
			plain_row("f", 1'b0), plain_row("a", 1'b0), plain_row("l", 1'b0),
			plain_row("s", 1'b0), plain_row("e", 1'b0),
			plain_row(8'hA5, 1'b1),
			plain_row(sexp_pkg::CH_QUOTE, 1'b0), plain_row(sexp_pkg::CH_NUL, 1'b0),
			plain_row(sexp_pkg::CH_SEMI, 1'b0),
			'{sexp_pkg::CH_NUL, 1'b1, 1'b1, sexp_pkg::KIND_EOF, sexp_pkg::ERR_NONE, 1, 0, 1}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_row(dir_tab[i]);

		while (rand_q.size() < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				add_ch($urandom_range(0, 1) == 0 ? sexp_pkg::CH_LBR : sexp_pkg::CH_RBR);
			end else if (pick < 30) begin
				n = $urandom_range(1, 4);
				repeat (n) add_ch(8'("0" + $urandom_range(0, 9)));
				k = $urandom_range(0, 9);
				if (k < 3) begin
					add_ch(sexp_pkg::CH_DOT);
					n = $urandom_range(1, 3);
					repeat (n) add_ch(8'("0" + $urandom_range(0, 9)));
				end else if (k < 5) begin
					add_ch(sexp_pkg::CH_DOT);
					add_ch(after_dot[$urandom_range(0, after_dot.len() - 1)]);
				end
			end else if (pick < 52) begin
				if ($urandom_range(0, 2) != 0) begin
					word = word_pool[$urandom_range(0, 9)];
					for (int j = 0; j < word.len(); j++) add_ch(word[j]);
				end else begin
					n = $urandom_range(1, 6);
					add_ch(lead_chars[$urandom_range(0, lead_chars.len() - 1)]);
					repeat (n - 1) add_ch(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
				end
			end else if (pick < 64) begin
				add_ch(sexp_pkg::CH_QUOTE);
				n = $urandom_range(0, 6);
				repeat (n) begin
					do ch = 8'($urandom_range(1, 255)); while (ch == sexp_pkg::CH_QUOTE);
					add_ch($urandom_range(0, 5) == 0 ? sexp_pkg::CH_LF : ch);
				end
				if ($urandom_range(0, 9) == 0) add_end();
				else add_ch(sexp_pkg::CH_QUOTE);
			end else if (pick < 72) begin
				add_ch(sexp_pkg::CH_SEMI);
				n = $urandom_range(0, 5);
				repeat (n) begin
					do ch = 8'($urandom_range(1, 255)); while (ch == sexp_pkg::CH_LF);
					add_ch(ch);
				end
				if ($urandom_range(0, 4) == 0) add_end();
				else add_ch(sexp_pkg::CH_LF);
			end else if (pick < 80) begin
				add_ch(8'($urandom_range(0, 255)));
			end else if (pick < 84) begin
				add_end();
			end
			k = $urandom_range(0, 9);
			if (k < 4) add_ch(CH_SP);
			else if (k == 4) add_ch(CH_TAB);
			else if (k == 5) add_ch(CH_CR);
			else if (k == 6) add_ch(sexp_pkg::CH_LF);
		end
		add_end();

		foreach (rand_q[i]) begin
			if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
			send_row(rand_q[i]);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_tokens.size() != 0)
			report_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
